// ----- design/closed_path_midpoint_upsampler_core_macros.svh -----
// assertion macros shared by the closed path midpoint upsampler modules
`ifndef CLOSED_PATH_MIDPOINT_UPSAMPLER_CORE_MACROS_SVH
`define CLOSED_PATH_MIDPOINT_UPSAMPLER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CPMU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CPMU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/cpmu_pkg.sv -----
// shared constants and types of the closed path midpoint upsampler
package cpmu_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int MAX_PASSES   = 5;
   localparam int PASSES_WIDTH = 3;
   localparam int K_WIDTH      = MAX_PASSES;
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int ACC_WIDTH    = DIFF_WIDTH + MAX_PASSES;

   // both queues hold two entries; pointers wrap by plain increment
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = 1;
   localparam int QUEUE_COUNT_WIDTH = 2;

   localparam logic [PASSES_WIDTH-1:0] PASSES_RESET = PASSES_WIDTH'(1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [ACC_WIDTH-1:0]   acc_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      diff_type x;
      diff_type y;
      diff_type z;
   } diff_vec_type;

   // one accepted point, turned into up to two segments
   typedef struct packed {
      point_type    from1;
      diff_vec_type d1;
      point_type    from2;
      diff_vec_type d2;
      logic         has_seg1;
      logic         has_seg2;
   } seg_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      point_type pt;
      logic      run_end;
   } result_type;

endpackage

// ----- design/cpmu_front.sv -----
// front end: takes path points, tracks first and previous point, issues segment commands
module cpmu_front
   import cpmu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  coord_type        req_coord_x,
   input  coord_type        req_coord_y,
   input  coord_type        req_coord_z,
   input  logic             req_final_point,
   input  queue_status_type q_status,
   output logic             q_push,
   output seg_cmd_type      q_cmd
);

   point_type prev_ff, prev_in;
   point_type first_ff, first_in;
   logic      have_first_ff, have_first_in;
   point_type cur;
   point_type first_eff;
   logic      accept;

   function automatic diff_type sub_ext(input coord_type a, input coord_type b);
      diff_type ea;
      diff_type eb;
      ea = {a[COORD_WIDTH-1], a};
      eb = {b[COORD_WIDTH-1], b};
      return ea - eb;
   endfunction

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   always_comb begin
      cur.x = req_coord_x;
      cur.y = req_coord_y;
      cur.z = req_coord_z;
      // a lone final point wraps onto itself
      first_eff = have_first_ff ? first_ff : cur;

      q_cmd.from1    = prev_ff;
      q_cmd.d1.x     = sub_ext(cur.x, prev_ff.x);
      q_cmd.d1.y     = sub_ext(cur.y, prev_ff.y);
      q_cmd.d1.z     = sub_ext(cur.z, prev_ff.z);
      q_cmd.from2    = cur;
      q_cmd.d2.x     = sub_ext(first_eff.x, cur.x);
      q_cmd.d2.y     = sub_ext(first_eff.y, cur.y);
      q_cmd.d2.z     = sub_ext(first_eff.z, cur.z);
      q_cmd.has_seg1 = have_first_ff;
      q_cmd.has_seg2 = req_final_point;

      q_push = accept && (have_first_ff || req_final_point);

      prev_in       = prev_ff;
      first_in      = first_ff;
      have_first_in = have_first_ff;
      if (accept) begin
         prev_in       = cur;
         first_in      = first_eff;
         have_first_in = !req_final_point;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      first_ff <= first_in;
      if (reset) begin
         have_first_ff <= 1'b0;
      end else begin
         have_first_ff <= have_first_in;
      end
   end

endmodule

// ----- design/cpmu_cmd_queue.sv -----
// two-entry queue of segment commands between front and back
module cpmu_cmd_queue
   import cpmu_pkg::*;
`include "closed_path_midpoint_upsampler_core_macros.svh"
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  seg_cmd_type      push_cmd,
   input  logic             pop,
   output seg_cmd_type      head_cmd,
   output queue_status_type status
);

   seg_cmd_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;

   assign head_cmd     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CPMU_ASSERT_SAME(a_no_push_full, clock, reset, push, !status.full, "push into full queue")
   `CPMU_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, !status.empty, "pop from empty queue")

endmodule

// ----- design/cpmu_back.sv -----
// back end: steps segments into a two-entry result buffer, one point per non-stalled cycle
module cpmu_back
   import cpmu_pkg::*;
`include "closed_path_midpoint_upsampler_core_macros.svh"
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [PASSES_WIDTH-1:0] passes,
   input  queue_status_type        q_status,
   input  seg_cmd_type             head_cmd,
   output logic                    q_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output coord_type               rsp_out_x,
   output coord_type               rsp_out_y,
   output coord_type               rsp_out_z,
   output logic                    rsp_run_end
);

   localparam logic [K_WIDTH-1:0] K_ONES = '1;

   logic [K_WIDTH-1:0]           k_ff, k_in;
   logic                         seg_ff, seg_in;
   acc_type                      acc_x_ff, acc_x_in;
   acc_type                      acc_y_ff, acc_y_in;
   acc_type                      acc_z_ff, acc_z_in;
   result_type                   out_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;

   logic [PASSES_WIDTH-1:0] p;
   logic [K_WIDTH-1:0]      k_last;
   logic                    sel2;
   point_type               from;
   diff_vec_type            d;
   logic                    last_k;
   logic                    last_seg;
   logic                    produce;
   logic                    out_pop;
   result_type              res;

   function automatic acc_type acc_add(input acc_type a, input diff_type dv);
      acc_type ext;
      ext = {{MAX_PASSES{dv[DIFF_WIDTH-1]}}, dv};
      return a + ext;
   endfunction

   // from + floor(acc / 2^p), wrapped to coordinate width
   function automatic coord_type interp(input coord_type c, input acc_type a,
                                        input logic [PASSES_WIDTH-1:0] sh);
      acc_type shifted;
      acc_type ext;
      acc_type sum;
      shifted = a >>> sh;
      ext     = {{(ACC_WIDTH-COORD_WIDTH){c[COORD_WIDTH-1]}}, c};
      sum     = ext + shifted;
      return sum[COORD_WIDTH-1:0];
   endfunction

   always_comb begin
      p = (passes > PASSES_WIDTH'(MAX_PASSES)) ? PASSES_WIDTH'(MAX_PASSES) : passes;
      k_last = ~(K_ONES << p);

      // skip the leading segment when the point opened the path
      sel2     = !head_cmd.has_seg1 || seg_ff;
      from     = sel2 ? head_cmd.from2 : head_cmd.from1;
      d        = sel2 ? head_cmd.d2 : head_cmd.d1;
      last_k   = (k_ff == k_last);
      last_seg = sel2 || !head_cmd.has_seg2;

      produce = !q_status.empty && (count_ff != QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
      q_pop   = produce && last_k && last_seg;

      res.pt.x    = interp(from.x, acc_x_ff, p);
      res.pt.y    = interp(from.y, acc_y_ff, p);
      res.pt.z    = interp(from.z, acc_z_ff, p);
      res.run_end = last_k && last_seg;

      k_in     = k_ff;
      seg_in   = seg_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      acc_z_in = acc_z_ff;
      if (produce) begin
         if (last_k) begin
            k_in     = '0;
            acc_x_in = '0;
            acc_y_in = '0;
            acc_z_in = '0;
            seg_in   = !last_seg;
         end else begin
            k_in     = k_ff + 1'b1;
            acc_x_in = acc_add(acc_x_ff, d.x);
            acc_y_in = acc_add(acc_y_ff, d.y);
            acc_z_in = acc_add(acc_z_ff, d.z);
         end
      end

      out_pop   = rsp_pop && !rsp_empty;
      wr_ptr_in = produce ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = out_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (produce && !out_pop) begin
         count_in = count_ff + 1'b1;
      end else if (out_pop && !produce) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign rsp_empty   = (count_ff == '0);
   assign rsp_out_x   = out_mem_ff[rd_ptr_ff].pt.x;
   assign rsp_out_y   = out_mem_ff[rd_ptr_ff].pt.y;
   assign rsp_out_z   = out_mem_ff[rd_ptr_ff].pt.z;
   assign rsp_run_end = out_mem_ff[rd_ptr_ff].run_end;

   always_ff @(posedge clock) begin
      if (produce) begin
         out_mem_ff[wr_ptr_ff] <= res;
      end
      if (reset) begin
         k_ff      <= '0;
         seg_ff    <= 1'b0;
         acc_x_ff  <= '0;
         acc_y_ff  <= '0;
         acc_z_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         k_ff      <= k_in;
         seg_ff    <= seg_in;
         acc_x_ff  <= acc_x_in;
         acc_y_ff  <= acc_y_in;
         acc_z_ff  <= acc_z_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CPMU_ASSERT_SAME(a_buf_bound, clock, reset, 1'b1, count_ff <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH), "result buffer overflow")
   `CPMU_ASSERT_NEXT(a_wrap_follows, clock, reset, produce && last_k && !last_seg, seg_ff && (k_ff == '0), "wrap segment not started")
   `CPMU_ASSERT_SAME(a_acc_idle, clock, reset, k_ff == '0, (acc_x_ff == '0) && (acc_y_ff == '0) && (acc_z_ff == '0), "accumulator not cleared at segment start")

endmodule

// ----- design/closed_path_midpoint_upsampler_core.sv -----
// top level of the closed path midpoint upsampler
// Takes signed Q8.8 3D points of a closed path, one per transfer on the req_ queue, with
// req_final_point marking the last point. For each segment from the previous point to the
// current one it emits 2^passes points prev + ((cur - prev) * k >>> passes), k counting up
// from 0, and on the final point also the segment back to the first point of the path.
// The first point of a path gives no results; a path of one point gives 2^passes copies of
// it. rsp_run_end marks the last result of each input point. The user must write passes
// through the csr_ port only while the block is idle; the block does not enforce it. Its
// effective value saturates at five. Results leave at one per cycle while a command is
// queued and the result buffer has room. The back end steps one segment per input point,
// or two on the final point of a path of two or more points.
// A two-entry command queue sits between the point tracker and the stepper, and a two-entry
// result buffer between the stepper and rsp_, so both sides stall independently.
module closed_path_midpoint_upsampler_core
   import cpmu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input point queue
   input  logic                    req_push,
   output logic                    req_full,
   input  coord_type               req_coord_x,
   input  coord_type               req_coord_y,
   input  coord_type               req_coord_z,
   input  logic                    req_final_point,
   // result queue
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output coord_type               rsp_out_x,
   output coord_type               rsp_out_y,
   output coord_type               rsp_out_z,
   output logic                    rsp_run_end,
   // passes register write
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [PASSES_WIDTH-1:0] csr_passes
);

   logic [PASSES_WIDTH-1:0] passes_ff, passes_in;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   seg_cmd_type      push_cmd;
   seg_cmd_type      head_cmd;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign passes_in = (csr_valid && csr_ready) ? csr_passes : passes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         passes_ff <= PASSES_RESET;
      end else begin
         passes_ff <= passes_in;
      end
   end

   // point tracker: first/previous point and segment classification
   cpmu_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_final_point (req_final_point),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   // decoupling queue of segment commands
   cpmu_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // segment stepper and result buffer
   cpmu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .passes      (passes_ff),
      .q_status    (q_status),
      .head_cmd    (head_cmd),
      .q_pop       (q_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .rsp_run_end (rsp_run_end)
   );

endmodule
